[src/kmsd_pkg.sv]
// Shared types and constants for the key matrix scanner with debounce.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package kmsd_pkg;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLUMNS = 32;
	localparam int ROW_W       = 8;
	localparam int COL_W       = 5;
	localparam int CNT_W       = 16;

	localparam logic [CNT_W-1:0] COUNT_MAX       = 16'hffff;
	localparam logic [CNT_W-1:0] THRESHOLD_RESET = 16'd5;
	localparam logic [5:0]       COLUMNS_RESET   = 6'd21;
	localparam logic [3:0]       ROWS_RESET      = 4'd6;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_COLUMNS   = 2'd1;
	localparam logic [1:0] REG_ROWS      = 2'd2;

	typedef enum logic [1:0] {
		PH_DRIVE    = 2'd0,
		PH_SAMPLE   = 2'd1,
		PH_DEBOUNCE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CNT_W-1:0] threshold;
		logic [5:0]       column_count;
		logic [3:0]       row_count;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] rows;
	} latch_t;

endpackage

`default_nettype wire

[src/kmsd_scan_fsm.sv]
// Scan phase machine: column stepping, debounce counter and latch decision.
// Depends on kmsd_pkg for the phase type, configuration and latch structs.
`default_nettype none

module kmsd_scan_fsm (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       step,
	input  wire [kmsd_pkg::ROW_W-1:0] row_active,
	input  kmsd_pkg::cfg_t            cfg,
	output kmsd_pkg::phase_t          phase_nxt,
	output logic [kmsd_pkg::COL_W-1:0] column_nxt,
	output kmsd_pkg::latch_t          latch
);

	kmsd_pkg::phase_t               phase_q;
	logic [kmsd_pkg::COL_W-1:0]     cur_col_q;
	logic [kmsd_pkg::COL_W-1:0]     next_col_q;
	logic [kmsd_pkg::CNT_W-1:0]     count_q;

	logic [kmsd_pkg::COL_W-1:0]     next_col_nxt;
	logic [kmsd_pkg::CNT_W-1:0]     count_inc;
	logic [kmsd_pkg::CNT_W-1:0]     count_nxt;
	logic [5:0]                     eff_cols;
	logic [3:0]                     eff_rows;
	logic [8:0]                     mask_wide;
	logic [kmsd_pkg::ROW_W-1:0]     rows;
	logic [kmsd_pkg::COL_W-1:0]     drive_col;
	logic [5:0]                     drive_inc;
	logic                           any_row;
	logic                           settled;

	always_comb begin
		eff_cols = cfg.column_count;
		if (cfg.column_count == 6'd0) begin
			eff_cols = 6'd1;
		end else if (cfg.column_count > 6'(kmsd_pkg::MAX_COLUMNS)) begin
			eff_cols = 6'(kmsd_pkg::MAX_COLUMNS);
		end
		eff_rows = cfg.row_count;
		if (cfg.row_count == 4'd0) begin
			eff_rows = 4'd1;
		end else if (cfg.row_count > 4'(kmsd_pkg::MAX_ROWS)) begin
			eff_rows = 4'(kmsd_pkg::MAX_ROWS);
		end
	end

	assign mask_wide = (9'd1 << eff_rows) - 9'd1;
	assign rows      = row_active & mask_wide[kmsd_pkg::ROW_W-1:0];
	assign any_row   = (rows != '0);
	assign count_inc = (count_q == kmsd_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
	assign settled   = (count_inc > cfg.threshold);

	// A stale next column left by a larger column count restarts at zero.
	assign drive_col = ({1'b0, next_col_q} < eff_cols) ? next_col_q : '0;
	assign drive_inc = {1'b0, drive_col} + 6'd1;

	// Next phase.
	always_comb begin
		case (phase_q)
			kmsd_pkg::PH_SAMPLE: begin
				phase_nxt = any_row ? kmsd_pkg::PH_DEBOUNCE : kmsd_pkg::PH_DRIVE;
			end
			kmsd_pkg::PH_DEBOUNCE: begin
				if (!any_row || settled) begin
					phase_nxt = kmsd_pkg::PH_DRIVE;
				end else begin
					phase_nxt = kmsd_pkg::PH_DEBOUNCE;
				end
			end
			default: begin
				phase_nxt = kmsd_pkg::PH_SAMPLE;
			end
		endcase
	end

	// Datapath updates for the current phase.
	always_comb begin
		count_nxt    = count_inc;
		column_nxt   = cur_col_q;
		next_col_nxt = next_col_q;
		latch        = '0;
		case (phase_q)
			kmsd_pkg::PH_SAMPLE: begin
				if (any_row) begin
					count_nxt = '0;
				end
			end
			kmsd_pkg::PH_DEBOUNCE: begin
				if (any_row && settled) begin
					count_nxt    = '0;
					latch.valid  = 1'b1;
					latch.column = cur_col_q;
					latch.rows   = rows;
				end
			end
			default: begin
				column_nxt   = drive_col;
				next_col_nxt = (drive_inc >= eff_cols) ? '0 : drive_inc[kmsd_pkg::COL_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kmsd_pkg::PH_DRIVE;
			cur_col_q  <= '0;
			next_col_q <= '0;
			count_q    <= '0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			cur_col_q  <= column_nxt;
			next_col_q <= next_col_nxt;
			count_q    <= count_nxt;
		end
	end

endmodule

`default_nettype wire

[src/kmsd_key_map.sv]
// Latched key map: one row mask per column, ORed on latch, cleared by reset.
// Depends on kmsd_pkg for the latch struct and widths.
`default_nettype none

module kmsd_key_map (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  kmsd_pkg::latch_t           latch,
	input  wire [kmsd_pkg::COL_W-1:0]  query_column,
	output logic [kmsd_pkg::ROW_W-1:0] query_rows
);

	logic [kmsd_pkg::ROW_W-1:0] map_q [kmsd_pkg::MAX_COLUMNS];
	logic                       wr_en;

	assign wr_en = step && latch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kmsd_pkg::MAX_COLUMNS; i++) begin
				map_q[i] <= '0;
			end
		end else if (wr_en) begin
			map_q[latch.column] <= map_q[latch.column] | latch.rows;
		end
	end

	// The query sees this item's own latch, so the write is bypassed here.
	always_comb begin
		query_rows = map_q[query_column];
		if (latch.valid && (latch.column == query_column)) begin
			query_rows = query_rows | latch.rows;
		end
	end

endmodule

`default_nettype wire

[src/key_matrix_scanner_debounce_core.sv]
// Top level of the key matrix scanner with debounce: input and result registers,
// configuration registers, and the scan machine and key map from kmsd_pkg users.
//
// Usage:
//   Each input item is one scan tick: row_active holds the sampled rows (bit set
//   when the row reads low) and query_column selects a key map entry to report.
//   Every item yields exactly one result item: the driven column, a latch report
//   (latch_valid, latch_column, latch_rows), the queried key map rows after the
//   tick, and the scan phase after the tick.
//   out_valid rises once an accepted item has passed the input register and the
//   result register; one item is taken every cycle while in_stall is low, as the
//   phase update between the input register and the result register is combinational.
//   When out_stall and out_valid are high the result register holds; the input register still
//   fills, and in_stall rises only while both registers are occupied.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
//   always ready; index 0 is the debounce threshold, 1 the column count and 2
//   the row count, other indexes are ignored. Write it only while idle.
//   Reset sets phase to column drive, column and counter to zero, clears the
//   whole key map and restores threshold 5, 21 columns and 6 rows.
`default_nettype none

module key_matrix_scanner_debounce_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] row_active,
	input  wire  [4:0] query_column,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [4:0] drive_column,
	output logic       latch_valid,
	output logic [4:0] latch_column,
	output logic [7:0] latch_rows,
	output logic [7:0] query_rows,
	output logic [1:0] scan_phase_out,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [1:0] cfg_index,
	input  wire [15:0] cfg_data
);

	kmsd_pkg::cfg_t             cfg_q;
	logic                       valid_s1;
	logic [7:0]                 rows_s1;
	logic [4:0]                 query_s1;
	logic                       out_valid_q;
	logic                       step;
	logic                       load;
	kmsd_pkg::phase_t           phase_nxt;
	logic [4:0]                 column_nxt;
	kmsd_pkg::latch_t           latch;
	logic [7:0]                 query_nxt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= kmsd_pkg::THRESHOLD_RESET;
			cfg_q.column_count <= kmsd_pkg::COLUMNS_RESET;
			cfg_q.row_count    <= kmsd_pkg::ROWS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				kmsd_pkg::REG_THRESHOLD: cfg_q.threshold    <= cfg_data;
				kmsd_pkg::REG_COLUMNS:   cfg_q.column_count <= cfg_data[5:0];
				kmsd_pkg::REG_ROWS:      cfg_q.row_count    <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rows_s1  <= row_active;
			query_s1 <= query_column;
		end
	end

	kmsd_scan_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.row_active (rows_s1),
		.cfg        (cfg_q),
		.phase_nxt  (phase_nxt),
		.column_nxt (column_nxt),
		.latch      (latch)
	);

	kmsd_key_map u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.latch        (latch),
		.query_column (query_s1),
		.query_rows   (query_nxt)
	);

	always_ff @(posedge clk) begin
		if (step) begin
			drive_column   <= column_nxt;
			latch_valid    <= latch.valid;
			latch_column   <= latch.column;
			latch_rows     <= latch.rows;
			query_rows     <= query_nxt;
			scan_phase_out <= 2'(phase_nxt);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
